### rtl/core/ps2_scancode_to_ascii_core_macros.svh
// Assertion macros shared by the scancode translator RTL.
`ifndef PS2_SCANCODE_TO_ASCII_CORE_MACROS_SVH
`define PS2_SCANCODE_TO_ASCII_CORE_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define PS2SC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ps2sc same-cycle check failed");

// Next-cycle implication, gated off during reset.
`define PS2SC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ps2sc next-cycle check failed");

`endif

### rtl/core/ps2sc_pkg.sv
// Types, scancode constants and ROM functions for the scancode translator.
package ps2sc_pkg;

   localparam logic [7:0] SC_ERR_LO     = 8'h00;
   localparam logic [7:0] SC_ERR_HI     = 8'hFF;
   localparam logic [7:0] SC_PREFIX     = 8'hE0;
   localparam logic [6:0] SC_LSHIFT     = 7'h2A;
   localparam logic [6:0] SC_RSHIFT     = 7'h36;
   localparam logic [7:0] SC_CAPS       = 8'h3A;
   localparam logic [6:0] SC_UP         = 7'd72;
   localparam logic [6:0] SC_LEFT       = 7'd75;
   localparam logic [6:0] SC_RIGHT      = 7'd77;
   localparam logic [6:0] SC_DOWN       = 7'd80;
   localparam logic [6:0] PLAIN_ROM_SIZE = 7'd90;
   localparam logic [6:0] SHIFT_ROM_SIZE = 7'd59;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_NAV  = 1'b1;

   typedef struct packed {
      logic shift_held;
      logic caps_on;
      logic extended_pending;
   } flags_type;

   typedef struct packed {
      logic       has_result;
      logic       kind;
      logic [6:0] code;
   } key_type;

   function automatic logic [6:0] plain_rom(input logic [6:0] idx);
      logic [6:0] ch;
      case (idx)
         7'd1:  ch = 7'h1B;
         7'd2:  ch = 7'h31;
         7'd3:  ch = 7'h32;
         7'd4:  ch = 7'h33;
         7'd5:  ch = 7'h34;
         7'd6:  ch = 7'h35;
         7'd7:  ch = 7'h36;
         7'd8:  ch = 7'h37;
         7'd9:  ch = 7'h38;
         7'd10: ch = 7'h39;
         7'd11: ch = 7'h30;
         7'd12: ch = 7'h2D;
         7'd13: ch = 7'h3D;
         7'd14: ch = 7'h08;
         7'd15: ch = 7'h09;
         7'd16: ch = 7'h71;
         7'd17: ch = 7'h77;
         7'd18: ch = 7'h65;
         7'd19: ch = 7'h72;
         7'd20: ch = 7'h74;
         7'd21: ch = 7'h79;
         7'd22: ch = 7'h75;
         7'd23: ch = 7'h69;
         7'd24: ch = 7'h6F;
         7'd25: ch = 7'h70;
         7'd26: ch = 7'h5B;
         7'd27: ch = 7'h5D;
         7'd28: ch = 7'h0A;
         7'd30: ch = 7'h61;
         7'd31: ch = 7'h73;
         7'd32: ch = 7'h64;
         7'd33: ch = 7'h66;
         7'd34: ch = 7'h67;
         7'd35: ch = 7'h68;
         7'd36: ch = 7'h6A;
         7'd37: ch = 7'h6B;
         7'd38: ch = 7'h6C;
         7'd39: ch = 7'h3B;
         7'd40: ch = 7'h27;
         7'd41: ch = 7'h60;
         7'd43: ch = 7'h5C;
         7'd44: ch = 7'h7A;
         7'd45: ch = 7'h78;
         7'd46: ch = 7'h63;
         7'd47: ch = 7'h76;
         7'd48: ch = 7'h62;
         7'd49: ch = 7'h6E;
         7'd50: ch = 7'h6D;
         7'd51: ch = 7'h2C;
         7'd52: ch = 7'h2E;
         7'd53: ch = 7'h2F;
         7'd55: ch = 7'h2A;
         7'd57: ch = 7'h20;
         7'd74: ch = 7'h2D;
         7'd78: ch = 7'h2B;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [6:0] shift_rom(input logic [6:0] idx);
      logic [6:0] ch;
      case (idx)
         7'd1:  ch = 7'h1B;
         7'd2:  ch = 7'h21;
         7'd3:  ch = 7'h40;
         7'd4:  ch = 7'h23;
         7'd5:  ch = 7'h24;
         7'd6:  ch = 7'h25;
         7'd7:  ch = 7'h5E;
         7'd8:  ch = 7'h26;
         7'd9:  ch = 7'h2A;
         7'd10: ch = 7'h28;
         7'd11: ch = 7'h29;
         7'd12: ch = 7'h5F;
         7'd13: ch = 7'h2B;
         7'd14: ch = 7'h08;
         7'd15: ch = 7'h09;
         7'd16: ch = 7'h51;
         7'd17: ch = 7'h57;
         7'd18: ch = 7'h45;
         7'd19: ch = 7'h52;
         7'd20: ch = 7'h54;
         7'd21: ch = 7'h59;
         7'd22: ch = 7'h55;
         7'd23: ch = 7'h49;
         7'd24: ch = 7'h4F;
         7'd25: ch = 7'h50;
         7'd26: ch = 7'h7B;
         7'd27: ch = 7'h7D;
         7'd28: ch = 7'h0A;
         7'd30: ch = 7'h41;
         7'd31: ch = 7'h53;
         7'd32: ch = 7'h44;
         7'd33: ch = 7'h46;
         7'd34: ch = 7'h47;
         7'd35: ch = 7'h48;
         7'd36: ch = 7'h4A;
         7'd37: ch = 7'h4B;
         7'd38: ch = 7'h4C;
         7'd39: ch = 7'h3A;
         7'd40: ch = 7'h22;
         7'd41: ch = 7'h7E;
         7'd43: ch = 7'h7C;
         7'd44: ch = 7'h5A;
         7'd45: ch = 7'h58;
         7'd46: ch = 7'h43;
         7'd47: ch = 7'h56;
         7'd48: ch = 7'h42;
         7'd49: ch = 7'h4E;
         7'd50: ch = 7'h4D;
         7'd51: ch = 7'h3C;
         7'd52: ch = 7'h3E;
         7'd53: ch = 7'h3F;
         7'd55: ch = 7'h2A;
         7'd57: ch = 7'h20;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

endpackage

### rtl/core/ps2sc_decode.sv
// Combinational scancode decode: flag update and character lookup.
module ps2sc_decode (
   input  logic [7:0]            scan_byte,
   input  ps2sc_pkg::flags_type  flags,
   output ps2sc_pkg::flags_type  flags_next,
   output ps2sc_pkg::key_type    key
);
   import ps2sc_pkg::*;

   logic [6:0] low7;
   logic [6:0] ch;
   logic [6:0] ch_case;
   logic       is_arrow;

   assign low7     = scan_byte[6:0];
   assign is_arrow = (low7 == SC_UP) || (low7 == SC_LEFT) ||
                     (low7 == SC_RIGHT) || (low7 == SC_DOWN);

   always_comb begin
      if (flags.shift_held && (low7 < SHIFT_ROM_SIZE)) begin
         ch = shift_rom(low7);
      end else begin
         ch = plain_rom(low7);
      end
      // caps lock flips letter case only
      if (flags.caps_on && (((ch >= 7'h61) && (ch <= 7'h7A)) ||
                            ((ch >= 7'h41) && (ch <= 7'h5A)))) begin
         ch_case = ch ^ 7'h20;
      end else begin
         ch_case = ch;
      end
   end

   always_comb begin
      flags_next     = flags;
      key.has_result = 1'b0;
      key.kind       = KIND_CHAR;
      key.code       = ch_case;
      if ((scan_byte == SC_ERR_LO) || (scan_byte == SC_ERR_HI)) begin
         flags_next.extended_pending = 1'b0;
      end else if (scan_byte == SC_PREFIX) begin
         flags_next.extended_pending = 1'b1;
      end else if (scan_byte[7]) begin
         // break code
         flags_next.extended_pending = 1'b0;
         if ((low7 == SC_LSHIFT) || (low7 == SC_RSHIFT)) begin
            flags_next.shift_held = 1'b0;
         end
      end else if ((low7 == SC_LSHIFT) || (low7 == SC_RSHIFT)) begin
         flags_next.shift_held = 1'b1;
      end else if (scan_byte == SC_CAPS) begin
         flags_next.caps_on          = ~flags.caps_on;
         flags_next.extended_pending = 1'b0;
      end else if (flags.extended_pending) begin
         flags_next.extended_pending = 1'b0;
         key.has_result              = is_arrow;
         key.kind                    = KIND_NAV;
         key.code                    = low7;
      end else if (low7 < PLAIN_ROM_SIZE) begin
         key.has_result = (ch_case != 7'h00);
      end
   end

endmodule

### rtl/core/ps2sc_out_stage.sv
// Result register for the translator's output channel.
module ps2sc_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  ps2sc_pkg::key_type key,
   output logic               can_load,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,   // [6:0] key_code, [7] zero
   output logic               rsp_tuser    // [0] key_kind
);
   import ps2sc_pkg::*;

   logic       valid_ff, valid_in;
   logic       kind_ff;
   logic [6:0] code_ff;

   assign can_load = ~valid_ff | rsp_tready;
   assign valid_in = load | (valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= key.kind;
         code_ff <= key.code;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, code_ff};
   assign rsp_tuser  = kind_ff;

endmodule

### rtl/core/ps2_scancode_to_ascii_core.sv
// PS/2 set-1 scancode to ASCII translator, top level.
// Path: an accepted scancode passes the input register, then the result register,
// which drives rsp_tvalid; it waits in the input register while the output is full.
// Throughput: one scancode per cycle while the output is not stalled; the decode
// between the two registers is one table lookup plus flag update.
// Reset: clears shift, caps lock, pending prefix and both valid bits.
module ps2_scancode_to_ascii_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] scan_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] key_code, [7] zero pad
   output logic       rsp_tuser    // [0] key_kind: 0 char, 1 arrow key
);
   import ps2sc_pkg::*;

`include "ps2_scancode_to_ascii_core_macros.svh"

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;

   // keyboard state, updated as each item leaves the input register
   flags_type  flags_ff, flags_in;
   flags_type  flags_next;
   key_type    key;

   logic       out_can_load;
   logic       s1_advance;
   logic       out_load;

   // helpers for the checks below
   logic       rsp_is_arrow;
   logic       caps_retire;

   ps2sc_decode u_decode (
      .scan_byte  (s1_byte_ff),
      .flags      (flags_ff),
      .flags_next (flags_next),
      .key        (key)
   );

   // an item with no result retires even while the output is full
   assign s1_advance  = s1_valid_ff & (~key.has_result | out_can_load);
   assign out_load    = s1_advance & key.has_result;
   assign req_tready  = ~s1_valid_ff | s1_advance;
   assign s1_valid_in = (req_tvalid & req_tready) | (s1_valid_ff & ~s1_advance);
   assign flags_in    = s1_advance ? flags_next : flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         flags_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         flags_ff    <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid & req_tready) begin
         s1_byte_ff <= req_tdata;
      end
   end

   ps2sc_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .key        (key),
      .can_load   (out_can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   assign rsp_is_arrow = (rsp_tdata[6:0] == SC_UP) || (rsp_tdata[6:0] == SC_LEFT) ||
                         (rsp_tdata[6:0] == SC_RIGHT) || (rsp_tdata[6:0] == SC_DOWN);
   assign caps_retire  = s1_advance && (s1_byte_ff == SC_CAPS);

   // navigation results carry only arrow codes
   `PS2SC_ASSERT_NOW(a_nav_is_arrow, clock, reset, rsp_tvalid && rsp_tuser, rsp_is_arrow)
   // characters are never NUL
   `PS2SC_ASSERT_NOW(a_char_nonzero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[6:0] != 7'h00)
   // with room downstream the input register never holds an item back
   `PS2SC_ASSERT_NOW(a_no_false_stall, clock, reset, !rsp_tvalid, req_tready)
   // caps lock moves only on a retired caps make code
   `PS2SC_ASSERT_NEXT(a_caps_stable, clock, reset, !caps_retire, $stable(flags_ff.caps_on))

endmodule

### test/tb_ps2_scancode_to_ascii_core.sv
// Self-checking testbench for the PS/2 set-1 scancode to ASCII translator.
module tb_ps2_scancode_to_ascii_core;
   import ps2sc_pkg::*;

   localparam int RANDOM_ITEMS = 680;
   localparam int STALL_LIMIT  = 3000;   // cycles with no handshake on either side
   localparam int HOLD_AT      = 150;    // result count at which the long stall starts
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;      // two register stages plus margin

   localparam logic TYPED = 1'b1;
   localparam logic PRED  = 1'b0;
   localparam logic HAS   = 1'b1;
   localparam logic NONE  = 1'b0;

   typedef struct packed {
      logic       kind;
      logic [6:0] code;
   } key_out_type;

   typedef struct packed {
      logic [7:0] scan;
      logic       typed;      // expectation is written in the row
      logic       typed_has;
      logic       kind;
      logic [6:0] code;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 27;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;

   ps2_scancode_to_ascii_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Character tables, set-1 make code order.
   logic [7:0] plain_chars [0:89] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
      8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
      8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
      8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
      8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   logic [7:0] shifted_chars [0:58] = '{
      8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
      8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
      8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
      8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
      8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
      8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
   };

   // Directed rows: error bytes, every arrow, prefix handling, shift, caps.
   stim_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{8'h1E,              TYPED, HAS,  KIND_CHAR, 7'h61},  // 'a' out of reset
      '{SC_ERR_LO,          TYPED, NONE, KIND_CHAR, 7'h00},
      '{SC_ERR_HI,          TYPED, NONE, KIND_CHAR, 7'h00},
      '{SC_PREFIX,          TYPED, NONE, KIND_CHAR, 7'h00},
      '{{1'b0, SC_UP},      TYPED, HAS,  KIND_NAV,  SC_UP},
      '{SC_PREFIX,          TYPED, NONE, KIND_CHAR, 7'h00},
      '{{1'b0, SC_LEFT},    TYPED, HAS,  KIND_NAV,  SC_LEFT},
      '{SC_PREFIX,          TYPED, NONE, KIND_CHAR, 7'h00},
      '{{1'b0, SC_RIGHT},   TYPED, HAS,  KIND_NAV,  SC_RIGHT},
      '{SC_PREFIX,          TYPED, NONE, KIND_CHAR, 7'h00},
      '{{1'b0, SC_DOWN},    TYPED, HAS,  KIND_NAV,  SC_DOWN},
      '{SC_PREFIX,          TYPED, NONE, KIND_CHAR, 7'h00},
      '{SC_ERR_HI,          TYPED, NONE, KIND_CHAR, 7'h00},  // drops the prefix
      '{{1'b0, SC_DOWN},    PRED,  NONE, KIND_CHAR, 7'h00},  // plain lookup now
      '{SC_PREFIX,          TYPED, NONE, KIND_CHAR, 7'h00},
      '{8'h1E,              PRED,  NONE, KIND_CHAR, 7'h00},  // extended non-arrow
      '{SC_PREFIX,          TYPED, NONE, KIND_CHAR, 7'h00},
      '{{1'b0, SC_LSHIFT},  PRED,  NONE, KIND_CHAR, 7'h00},  // prefix survives
      '{{1'b0, SC_UP},      PRED,  NONE, KIND_CHAR, 7'h00},
      '{8'h02,              PRED,  NONE, KIND_CHAR, 7'h00},  // shifted digit
      '{8'h4A,              PRED,  NONE, KIND_CHAR, 7'h00},  // keypad, above shift table
      '{SC_CAPS,            PRED,  NONE, KIND_CHAR, 7'h00},
      '{8'h10,              PRED,  NONE, KIND_CHAR, 7'h00},  // shift and caps cancel
      '{{1'b1, SC_LSHIFT},  PRED,  NONE, KIND_CHAR, 7'h00},
      '{{1'b0, SC_RSHIFT},  PRED,  NONE, KIND_CHAR, 7'h00},
      '{8'h35,              PRED,  NONE, KIND_CHAR, 7'h00},
      '{8'h5A,              TYPED, NONE, KIND_CHAR, 7'h00}   // unmapped make code
   };

   // Keyboard state mirror
   logic shift_down  = 1'b0;
   logic caps_active = 1'b0;
   logic e0_seen     = 1'b0;

   key_out_type pending_keys [$];
   int       errors = 0;
   int       results_seen = 0;
   bit       sender_burst = 1'b0;
   bit       receiver_burst = 1'b0;
   int       idle_cycles = 0;

   task automatic translate_scan(input logic [7:0] scan, output logic produced,
                                 output key_out_type key);
      logic [7:0] ch;
      produced = 1'b0;
      key      = '{kind: KIND_CHAR, code: 7'h00};
      if (scan == SC_ERR_LO || scan == SC_ERR_HI) begin
         e0_seen = 1'b0;
      end else if (scan == SC_PREFIX) begin
         e0_seen = 1'b1;
      end else if (scan[7]) begin
         e0_seen = 1'b0;
         if (scan[6:0] == SC_LSHIFT || scan[6:0] == SC_RSHIFT) shift_down = 1'b0;
      end else if (scan[6:0] == SC_LSHIFT || scan[6:0] == SC_RSHIFT) begin
         shift_down = 1'b1;
      end else if (scan == SC_CAPS) begin
         caps_active = !caps_active;
         e0_seen     = 1'b0;
      end else if (e0_seen) begin
         e0_seen = 1'b0;
         if (scan[6:0] == SC_UP || scan[6:0] == SC_LEFT ||
             scan[6:0] == SC_RIGHT || scan[6:0] == SC_DOWN) begin
            produced = 1'b1;
            key      = '{kind: KIND_NAV, code: scan[6:0]};
         end
      end else if (scan[6:0] < PLAIN_ROM_SIZE) begin
         if (shift_down && scan[6:0] < SHIFT_ROM_SIZE) ch = shifted_chars[scan[5:0]];
         else ch = plain_chars[scan[6:0]];
         if (caps_active) begin
            if (ch >= "a" && ch <= "z") ch = ch - "a" + "A";
            else if (ch >= "A" && ch <= "Z") ch = ch - "A" + "a";
         end
         if (ch != 8'h00) begin
            produced = 1'b1;
            key      = '{kind: KIND_CHAR, code: ch[6:0]};
         end
      end
   endtask

   // Offer one scancode, wait for the handshake, record what should come out.
   task automatic send_scan(input logic [7:0] scan, input logic typed,
                            input logic typed_has, input key_out_type typed_key);
      int unsigned gap;
      logic        produced;
      key_out_type key;
      gap = sender_burst ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= scan;
      do @(posedge clock); while (!req_tready);
      translate_scan(scan, produced, key);
      if (typed) begin
         produced = typed_has;
         key      = typed_key;
      end
      if (produced) pending_keys.push_back(key);
   endtask

   function automatic logic [7:0] any_arrow();
      case ($urandom_range(0, 3))
         0:       return {1'b0, SC_UP};
         1:       return {1'b0, SC_LEFT};
         2:       return {1'b0, SC_RIGHT};
         default: return {1'b0, SC_DOWN};
      endcase
   endfunction

   task automatic send_keystrokes();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         send_scan(8'($urandom_range(1, 89)), PRED, NONE, '0);
      end else if (pick < 50) begin
         send_scan({1'b1, 7'($urandom_range(1, 89))}, PRED, NONE, '0);
      end else if (pick < 58) begin
         send_scan({1'b0, $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT}, PRED, NONE, '0);
      end else if (pick < 66) begin
         send_scan({1'b1, $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT}, PRED, NONE, '0);
      end else if (pick < 71) begin
         send_scan(SC_CAPS, PRED, NONE, '0);
      end else if (pick < 83) begin
         send_scan(SC_PREFIX, PRED, NONE, '0);
         send_scan(any_arrow(), PRED, NONE, '0);
      end else if (pick < 88) begin
         // prefix followed by anything, broken sequences included
         send_scan(SC_PREFIX, PRED, NONE, '0);
         send_scan(8'($urandom_range(0, 255)), PRED, NONE, '0);
      end else begin
         send_scan(8'($urandom_range(0, 255)), PRED, NONE, '0);
      end
   endtask

   // Stimulus and final verdict
   initial begin
      int sent;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_scan(directed_rows[i].scan, directed_rows[i].typed, directed_rows[i].typed_has,
                   {directed_rows[i].kind, directed_rows[i].code});
      for (sent = 0; sent < RANDOM_ITEMS; sent++) begin
         if ($urandom_range(0, 39) == 0) sender_burst = !sender_burst;
         send_keystrokes();
      end
      req_tvalid <= 1'b0;
      while (pending_keys.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   // Result side: random back-pressure, one long hold-off, field checks.
   initial begin
      int unsigned gap;
      int          hold;
      key_out_type want;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 39) == 0) receiver_burst = !receiver_burst;
         gap = receiver_burst ? 0 : $urandom_range(0, 16);
         if (results_seen == HOLD_AT) begin
            // long stall so the pipeline fills and backs up the input
            rsp_tready <= 1'b0;
            for (hold = 0; hold < HOLD_CYCLES; hold++) @(posedge clock);
         end else if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         results_seen++;
         if (pending_keys.size() == 0) begin
            $error("unexpected result: key_kind %0d key_code %0h", rsp_tuser, rsp_tdata[6:0]);
            errors++;
         end else begin
            want = pending_keys.pop_front();
            if (rsp_tuser !== want.kind) begin
               $error("key_kind: expected %0d, got %0d", want.kind, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[6:0] !== want.code) begin
               $error("key_code: expected %0h, got %0h", want.code, rsp_tdata[6:0]);
               errors++;
            end
            if (rsp_tdata[7] !== 1'b0) begin
               $error("pad bit: expected 0, got %0b", rsp_tdata[7]);
               errors++;
            end
         end
      end
   end

   // Watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
